// ----- design/brb_pkg.sv -----
// Package for the byte ring buffer with block operations.
// Holds sizes, command and status codes, item structs and pointer helpers.
// No dependencies.
package brb_pkg;

    localparam int DEPTH     = 1024;
    localparam int MAX_BLOCK = 64;
    localparam int PTR_W     = $clog2(DEPTH);
    localparam int CAP_W     = 11;
    localparam int LEN_W     = 11;
    localparam int CNT_W     = $clog2(MAX_BLOCK + 1);

    typedef enum logic [2:0] {
        CMD_CLEAR   = 3'd0,
        CMD_PUSH    = 3'd1,
        CMD_POP     = 3'd2,
        CMD_PEEK    = 3'd3,
        CMD_DISCARD = 3'd4,
        CMD_STATUS  = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_SHORT = 2'd1,
        STS_LONG  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } t_state;

    typedef struct packed {
        t_cmd             command;
        logic [7:0]       data_byte;
        logic [LEN_W-1:0] block_len;
        logic             block_start;
    } t_in_item;

    typedef struct packed {
        t_status    status;
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last;
        logic [9:0] fill_level;
        logic [9:0] spare_room;
        logic       is_full;
        logic       is_empty;
    } t_out_item;

    typedef struct packed {
        t_status          status;
        logic             byte_valid;
        logic             last;
        logic [PTR_W-1:0] rp;
        logic [PTR_W-1:0] wp;
    } t_stage;

    typedef struct packed {
        logic [PTR_W-1:0] fill;
        logic [CAP_W-1:0] spare;
        logic             full;
        logic             empty;
    } t_flags;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p,
                                                 input logic [CAP_W-1:0] ring);
        logic [CAP_W-1:0] sum;
        sum = {1'b0, p} + CAP_W'(1);
        if (sum == ring) begin
            sum = '0;
        end
        return sum[PTR_W-1:0];
    endfunction

    function automatic t_flags ring_flags(input logic [PTR_W-1:0] rp,
                                          input logic [PTR_W-1:0] wp,
                                          input logic [CAP_W-1:0] ring);
        t_flags           f;
        logic [CAP_W-1:0] fill;
        if (wp >= rp) begin
            fill = {1'b0, wp} - {1'b0, rp};
        end else begin
            fill = ring + {1'b0, wp} - {1'b0, rp};
        end
        f.fill  = fill[PTR_W-1:0];
        f.spare = ring - fill - CAP_W'(1);
        f.full  = (ptr_inc(wp, ring) == rp);
        f.empty = (rp == wp);
        return f;
    endfunction

endpackage

// ----- design/brb_ram.sv -----
// Byte storage of the ring buffer: one write port and one registered read port.
// Depends on brb_pkg for depth and address width.
module brb_ram
    import brb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [PTR_W-1:0] i_waddr,
    input  logic [7:0]       i_wdata,
    input  logic             i_re,
    input  logic [PTR_W-1:0] i_raddr,
    output logic [7:0]       o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/byte_ring_buffer_block_ops.sv -----
// Byte ring buffer with block push, pop, peek, discard, clear and status commands.
// Single-result items: one accepted per cycle unless stalled; the result passes
// through the s1 and output registers. Pop and peek of N bytes: the accepting cycle
// sets up the read, then one byte per cycle from the RAM read port unless stalled.
// Synchronous active-low reset empties the ring and sets the ring size to 1024.
// Depends on brb_pkg and brb_ram.
module byte_ring_buffer_block_ops
    import brb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CAP_W-1:0] i_cfg_data
);

    t_state           r_state, n_state;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [PTR_W-1:0] r_wp, n_wp;
    logic             r_push_acc, n_push_acc;
    logic [CAP_W-1:0] r_ring, n_ring;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [PTR_W-1:0] r_cur, n_cur;
    logic             r_is_pop, n_is_pop;
    logic             r_s1_valid;
    t_stage           r_s1, n_s1;
    logic             r_out_valid;
    t_out_item        r_out, n_out;

    logic             in_acc, cfg_acc, out_free, s1_free, s1_load;
    logic             mem_we, mem_re;
    logic [PTR_W-1:0] mem_raddr;
    logic [7:0]       mem_rdata;
    t_flags           flags_now, flags_s1;
    logic [PTR_W-1:0] wp_inc, cur_inc;
    logic [CAP_W:0]   disc_sum;
    logic [CAP_W-1:0] cfg_ring;
    logic [LEN_W-1:0] len;

    assign len       = i_in_data.block_len;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign s1_free   = !r_s1_valid || out_free;
    assign o_in_stall  = (r_state != ST_IDLE) || !s1_free || i_cfg_valid;
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign in_acc    = i_in_valid && !o_in_stall;
    assign cfg_acc   = i_cfg_valid && o_cfg_ready;

    assign flags_now = ring_flags(r_rp, r_wp, r_ring);
    assign wp_inc    = ptr_inc(r_wp, r_ring);
    assign cur_inc   = ptr_inc(r_cur, r_ring);

    always_comb begin
        disc_sum = {2'b00, r_rp} + {1'b0, len};
        if (disc_sum >= {1'b0, r_ring}) begin
            disc_sum = disc_sum - {1'b0, r_ring};
        end
    end

    always_comb begin
        if (i_cfg_data < CAP_W'(2)) begin
            cfg_ring = CAP_W'(2);
        end else if (i_cfg_data > CAP_W'(DEPTH)) begin
            cfg_ring = CAP_W'(DEPTH);
        end else begin
            cfg_ring = i_cfg_data;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_rp       = r_rp;
        n_wp       = r_wp;
        n_push_acc = r_push_acc;
        n_ring     = r_ring;
        n_cnt      = r_cnt;
        n_cur      = r_cur;
        n_is_pop   = r_is_pop;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_raddr  = r_cur;
        s1_load    = 1'b0;
        n_s1.status     = STS_OK;
        n_s1.byte_valid = 1'b0;
        n_s1.last       = 1'b1;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    s1_load = 1'b1;
                    case (i_in_data.command)
                        CMD_CLEAR: begin
                            n_rp       = '0;
                            n_wp       = '0;
                            n_push_acc = 1'b0;
                        end
                        CMD_PUSH: begin
                            if (i_in_data.block_start) begin
                                n_push_acc = (flags_now.spare >= len);
                            end
                            if (n_push_acc && !flags_now.full) begin
                                mem_we = 1'b1;
                                n_wp   = wp_inc;
                            end else begin
                                n_s1.status = STS_SHORT;
                            end
                        end
                        CMD_POP, CMD_PEEK: begin
                            if (len > LEN_W'(MAX_BLOCK)) begin
                                n_s1.status = STS_LONG;
                            end else if ({1'b0, flags_now.fill} < len) begin
                                n_s1.status = STS_SHORT;
                            end else if (len != '0) begin
                                s1_load  = 1'b0;
                                n_state  = ST_READ;
                                n_cnt    = len[CNT_W-1:0];
                                n_cur    = r_rp;
                                n_is_pop = (i_in_data.command == CMD_POP);
                            end
                        end
                        CMD_DISCARD: begin
                            if ({1'b0, flags_now.fill} < len) begin
                                n_s1.status = STS_SHORT;
                            end else begin
                                n_rp = disc_sum[PTR_W-1:0];
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (s1_free) begin
                    mem_re          = 1'b1;
                    s1_load         = 1'b1;
                    n_cur           = cur_inc;
                    n_s1.byte_valid = 1'b1;
                    n_s1.last       = (r_cnt == CNT_W'(1));
                    n_cnt           = r_cnt - CNT_W'(1);
                    if (r_is_pop) begin
                        n_rp = cur_inc;
                    end
                    if (r_cnt == CNT_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (cfg_acc) begin
            n_ring     = cfg_ring;
            n_rp       = '0;
            n_wp       = '0;
            n_push_acc = 1'b0;
        end

        n_s1.rp = n_rp;
        n_s1.wp = n_wp;
    end

    brb_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_wp),
        .i_wdata (i_in_data.data_byte),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign flags_s1 = ring_flags(r_s1.rp, r_s1.wp, r_ring);

    always_comb begin
        n_out.status     = r_s1.status;
        n_out.out_byte   = r_s1.byte_valid ? mem_rdata : 8'd0;
        n_out.byte_valid = r_s1.byte_valid;
        n_out.last       = r_s1.last;
        n_out.fill_level = flags_s1.fill;
        n_out.spare_room = flags_s1.spare[9:0];
        n_out.is_full    = flags_s1.full;
        n_out.is_empty   = flags_s1.empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rp        <= '0;
            r_wp        <= '0;
            r_push_acc  <= 1'b0;
            r_ring      <= CAP_W'(DEPTH);
            r_cnt       <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rp       <= n_rp;
            r_wp       <= n_wp;
            r_push_acc <= n_push_acc;
            r_ring     <= n_ring;
            r_cnt      <= n_cnt;
            if (s1_free) begin
                r_s1_valid <= s1_load;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur    <= n_cur;
        r_is_pop <= n_is_pop;
        if (s1_free && s1_load) begin
            r_s1 <= n_s1;
        end
        if (out_free && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- design/brb_checker.sv -----
// Port-level checker for the byte ring buffer, bound to the top level.
// Depends on brb_pkg and byte_ring_buffer_block_ops.
module brb_checker
    import brb_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input t_in_item         i_in_data,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input t_out_item        o_out_data,
    input logic             i_cfg_valid,
    input logic             o_cfg_ready,
    input logic [CAP_W-1:0] i_cfg_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("Result changed while stalled.");

    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != STS_OK)
        |-> o_out_data.last && !o_out_data.byte_valid)
        else $error("Error result is not a single last item without data.");

    a_no_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.byte_valid |-> (o_out_data.out_byte == 8'd0))
        else $error("Byte field is nonzero without a read byte.");

    a_empty_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.is_empty == (o_out_data.fill_level == 10'd0))
                        && !(o_out_data.is_full && o_out_data.is_empty))
        else $error("Empty flag disagrees with the fill level.");

endmodule

bind byte_ring_buffer_block_ops brb_checker u_brb_checker (.*);
